[sv/vtdec_pkg.sv]
// Shared types, codes and constants for the VT100 escape command decoder.
package vtdec_pkg;

   // Default number of parameter slots of a control sequence
   localparam int PARAM_SLOTS_DEF = 16;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int ARG_W  = 16;
   localparam int CLR_W  = 3;
   localparam int CMD_W  = 4;
   localparam int CSR_IDX_W = 2;

   // Default colours
   localparam logic [CLR_W-1:0] FG_DEFAULT = 3'd7;
   localparam logic [CLR_W-1:0] BG_DEFAULT = 3'd0;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_TOP    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BOTTOM = 2'd3;

   // Control bytes
   localparam logic [7:0] BYTE_NUL = 8'd0;
   localparam logic [7:0] BYTE_BEL = 8'd7;
   localparam logic [7:0] BYTE_BS  = 8'd8;
   localparam logic [7:0] BYTE_TAB = 8'd9;
   localparam logic [7:0] BYTE_LF  = 8'd10;
   localparam logic [7:0] BYTE_VT  = 8'd11;
   localparam logic [7:0] BYTE_FF  = 8'd12;
   localparam logic [7:0] BYTE_CR  = 8'd13;
   localparam logic [7:0] BYTE_SO  = 8'd14;
   localparam logic [7:0] BYTE_SI  = 8'd15;
   localparam logic [7:0] BYTE_CAN = 8'd24;
   localparam logic [7:0] BYTE_SUB = 8'd26;
   localparam logic [7:0] BYTE_ESC = 8'd27;
   localparam logic [7:0] BYTE_CSI = 8'd155;

   // Printable bytes with a meaning in sequences
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_B   = 8'h42;
   localparam logic [7:0] CH_UC_C   = 8'h43;
   localparam logic [7:0] CH_UC_D   = 8'h44;
   localparam logic [7:0] CH_UC_E   = 8'h45;
   localparam logic [7:0] CH_UC_H   = 8'h48;
   localparam logic [7:0] CH_UC_J   = 8'h4A;
   localparam logic [7:0] CH_UC_K   = 8'h4B;
   localparam logic [7:0] CH_UC_L   = 8'h4C;
   localparam logic [7:0] CH_UC_M   = 8'h4D;
   localparam logic [7:0] CH_UC_P   = 8'h50;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_LC_C   = 8'h63;
   localparam logic [7:0] CH_LC_H   = 8'h68;
   localparam logic [7:0] CH_LC_L   = 8'h6C;
   localparam logic [7:0] CH_LC_M   = 8'h6D;
   localparam logic [7:0] CH_LC_R   = 8'h72;

   // SGR and DEC mode values
   localparam logic [15:0] SGR_RESET  = 16'd0;
   localparam logic [15:0] SGR_FG_LO  = 16'd30;
   localparam logic [15:0] SGR_FG_HI  = 16'd37;
   localparam logic [15:0] SGR_FG_DEF = 16'd39;
   localparam logic [15:0] SGR_BG_LO  = 16'd40;
   localparam logic [15:0] SGR_BG_HI  = 16'd47;
   localparam logic [15:0] SGR_BG_DEF = 16'd49;
   localparam logic [15:0] DEC_BELL   = 16'd5;
   localparam logic [15:0] DEC_CURSOR = 16'd25;

   // Display command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUTCHAR   = 4'd0,
      CMD_BELL      = 4'd1,
      CMD_BACKSPACE = 4'd2,
      CMD_CURSOR    = 4'd3,
      CMD_ERASE     = 4'd4,
      CMD_CLEAR     = 4'd5,
      CMD_INS_LINES = 4'd6,
      CMD_DEL_LINES = 4'd7,
      CMD_DEL_CHARS = 4'd8,
      CMD_INS_CHARS = 4'd9,
      CMD_REGION    = 4'd10,
      CMD_VISIBLE   = 4'd11,
      CMD_RESET     = 4'd12
   } cmd_type;

   // Escape parser states
   typedef enum logic [2:0] {
      ESC_NORMAL = 3'd0,
      ESC_ESC    = 3'd1,
      ESC_CSI    = 3'd2,
      ESC_DEC    = 3'd3,
      ESC_G0     = 3'd4,
      ESC_G1     = 3'd5,
      ESC_HASH   = 3'd6,
      ESC_DCS    = 3'd7
   } esc_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;     // take the input item
      logic decode;    // decode latched byte, update parser state
      logic send_res;  // load result register into output
      logic send_lf;   // load result register with LF as character
      logic last;      // last flag for send_res / send_lf
      logic walk_m;    // one step of the SGR colour walk
      logic walk_d;    // one step of the DEC mode walk
      logic flush;     // send pending DEC result as last
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] n_res;      // results from decode: 0, 1 or 2
      logic       walk_m;     // decode starts colour walk
      logic       walk_d;     // decode starts DEC walk
      logic       out_free;   // output register can take an item
      logic       walk_done;  // walk is at the last parameter
      logic       walk_stall; // DEC walk step must wait for output
      logic       pend_after; // a DEC result is pending after this step
   } dp_stat_type;

endpackage

[sv/vt100_escape_command_decoder.sv]
// Top level of the VT100 escape command decoder: stream ports and packing.
//
// Takes one terminal byte with the display's cursor position per item and
// returns the display commands that byte causes, zero to sixteen items, the
// final one marked by rsp_tlast. One byte is handled at a time: a new item
// is taken only once the controller is back in idle.
// The SGR (CSI m) and DEC mode (CSI ? h / l) terminators walk the stored
// parameters through a single read port, one slot per cycle, a DEC walk step
// waiting while its result cannot go to a busy output. Configuration writes
// are always accepted and are meant to happen while idle.
module vt100_escape_command_decoder #(
   parameter int PARAM_SLOTS = vtdec_pkg::PARAM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // item in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_in[7:0], cursor_col[15:8], cursor_row[23:16]
   // item out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // command[3:0], arg_a[19:4], arg_b[35:20],
                                    // fg_colour[38:36], bg_colour[41:39], zero[47:42]
   output logic        rsp_tlast,   // last command of this byte
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import vtdec_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic [CMD_W-1:0] command;
   logic [ARG_W-1:0] arg_a, arg_b;
   logic [CLR_W-1:0] fg, bg;

   assign csr_ready = 1'b1;

   vtdec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vtdec_dp #(
      .PARAM_SLOTS (PARAM_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .byte_in     (req_tdata[7:0]),
      .cursor_col  (req_tdata[15:8]),
      .cursor_row  (req_tdata[23:16]),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_command (command),
      .rsp_arg_a   (arg_a),
      .rsp_arg_b   (arg_b),
      .rsp_fg      (fg),
      .rsp_bg      (bg),
      .rsp_last    (rsp_tlast)
   );

   // Pack result fields, lowest first
   assign rsp_tdata = {6'd0, bg, fg, arg_b, arg_a, command};

endmodule

[sv/vtdec_ctrl.sv]
// Controller state machine of the VT100 escape command decoder.
module vtdec_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  vtdec_pkg::dp_stat_type stat,
   output vtdec_pkg::ctrl_cmd_type cmd
);
   import vtdec_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECODE   = 8'b0000_0010,
      S_SEND_ONE = 8'b0000_0100,
      S_SEND_A   = 8'b0000_1000,
      S_SEND_B   = 8'b0001_0000,
      S_WALK_M   = 8'b0010_0000,
      S_WALK_D   = 8'b0100_0000,
      S_FLUSH    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.walk_m) begin
               state_in = S_WALK_M;
            end else if (stat.walk_d) begin
               state_in = S_WALK_D;
            end else if (stat.n_res == 2'd2) begin
               state_in = S_SEND_A;
            end else if (stat.n_res == 2'd1) begin
               state_in = S_SEND_ONE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SEND_ONE: begin
            if (stat.out_free) begin
               cmd.send_res = 1'b1;
               cmd.last     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SEND_A: begin
            if (stat.out_free) begin
               cmd.send_res = 1'b1;
               state_in     = S_SEND_B;
            end
         end
         S_SEND_B: begin
            if (stat.out_free) begin
               cmd.send_lf = 1'b1;
               cmd.last    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_WALK_M: begin
            cmd.walk_m = 1'b1;
            if (stat.walk_done) begin
               state_in = S_IDLE;
            end
         end
         S_WALK_D: begin
            cmd.walk_d = 1'b1;
            if (!stat.walk_stall && stat.walk_done) begin
               state_in = stat.pend_after ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/vtdec_dp.sv]
// Datapath of the VT100 escape command decoder: parser state, parameters,
// colours, result arithmetic and the output register.
module vtdec_dp #(
   parameter int PARAM_SLOTS = vtdec_pkg::PARAM_SLOTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vtdec_pkg::ctrl_cmd_type               cmd,
   output vtdec_pkg::dp_stat_type                stat,
   input  logic [vtdec_pkg::BYTE_W-1:0]          byte_in,
   input  logic [vtdec_pkg::BYTE_W-1:0]          cursor_col,
   input  logic [vtdec_pkg::BYTE_W-1:0]          cursor_row,
   input  logic                                  csr_valid,
   input  logic [vtdec_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vtdec_pkg::BYTE_W-1:0]          csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [vtdec_pkg::CMD_W-1:0]           rsp_command,
   output logic [vtdec_pkg::ARG_W-1:0]           rsp_arg_a,
   output logic [vtdec_pkg::ARG_W-1:0]           rsp_arg_b,
   output logic [vtdec_pkg::CLR_W-1:0]           rsp_fg,
   output logic [vtdec_pkg::CLR_W-1:0]           rsp_bg,
   output logic                                  rsp_last
);
   import vtdec_pkg::*;

   localparam int IDX_W = $clog2(PARAM_SLOTS);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(PARAM_SLOTS - 1);

   // Configuration
   logic [7:0] width_ff, height_ff, rtop_ff, rbot_ff;

   // Latched input item
   logic [7:0] byte_ff, col_ff, row_ff;

   // Parser state
   esc_type          esc_ff, esc_in;
   logic [15:0]      params_ff [PARAM_SLOTS];
   logic [15:0]      params_in [PARAM_SLOTS];
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [2:0]       fg_ff, fg_in, bg_ff, bg_in;

   // Result holding and walk
   cmd_type          res_cmd_ff;
   logic [15:0]      res_a_ff, res_b_ff;
   logic [2:0]       res_fg_ff, res_bg_ff;
   logic [IDX_W-1:0] walk_ff, walk_in;
   logic             pend_valid_ff, pend_valid_in;
   cmd_type          pend_cmd_ff, pend_cmd_in;
   logic             pend_on_ff, pend_on_in;

   // Output register
   logic        out_valid_ff, out_valid_in;
   cmd_type     out_cmd_ff, out_cmd_in;
   logic [15:0] out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [2:0]  out_fg_ff, out_fg_in, out_bg_ff, out_bg_in;
   logic        out_last_ff, out_last_in;

   // Decode results
   cmd_type     d_cmd;
   logic [15:0] d_a, d_b;
   logic [1:0]  d_n;
   logic        d_colours, d_digit, d_sep, d_clear, d_walk_m, d_walk_d;

   logic [15:0] p0, p1, f, rd_val, digit_sum;
   logic [IDX_W-1:0] rd_idx;
   logic        is_digit, dec_on, out_free;
   logic        walk_hit, step_stall, walk_done, walk_end;
   cmd_type     hit_cmd;

   logic signed [17:0] col_s, row_s, f_s, w_s, h_s, rt_s, rb_s, mx, my;
   logic [15:0] hx, hy, rx, ry;
   logic [2:0]  fg_code;

   // Shared parameter read: walk index while walking, else the fill slot
   assign rd_idx = (cmd.walk_m || cmd.walk_d) ? walk_ff : pidx_ff;
   assign rd_val = params_ff[rd_idx];
   assign p0     = params_ff[0];
   assign p1     = params_ff[1];
   assign f      = (p0 == 16'd0) ? 16'd1 : p0;

   // value * 10 + digit; the digit is the low nibble of its code
   assign digit_sum = (rd_val << 3) + (rd_val << 1) + {12'd0, byte_ff[3:0]};
   assign is_digit  = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);

   // Relative cursor moves
   assign col_s = $signed({10'd0, col_ff});
   assign row_s = $signed({10'd0, row_ff});
   assign f_s   = $signed({2'd0, f});
   assign w_s   = $signed({10'd0, width_ff});
   assign h_s   = $signed({10'd0, height_ff});
   assign rt_s  = $signed({10'd0, rtop_ff});
   assign rb_s  = $signed({10'd0, rbot_ff});

   always_comb begin
      mx = col_s;
      if (byte_ff == CH_UC_C) mx = col_s + f_s;
      if (byte_ff == CH_UC_D) mx = col_s - f_s;
      if (mx >= w_s) mx = w_s - 18'sd1;
      if (mx < 18'sd0) mx = 18'sd0;
      my = row_s;
      if (byte_ff == CH_UC_B) begin
         my = row_s + f_s;
         if (my >= h_s) my = h_s - 18'sd1;
         if (my >= rb_s + 18'sd1) my = rb_s;
      end else if (byte_ff == CH_UC_A) begin
         my = row_s - f_s;
         if (my < 18'sd0) my = 18'sd0;
         if (my <= rt_s - 18'sd1) my = rt_s;
      end
      if (my < 18'sd0) my = 18'sd0;
   end

   // Absolute position and scroll region
   always_comb begin
      hy = (p0 == 16'd0) ? 16'd1 : p0;
      hx = (p1 == 16'd0) ? 16'd1 : p1;
      if (hx >= {8'd0, width_ff}) hx = {8'd0, width_ff};
      if (hy >= {8'd0, height_ff}) hy = {8'd0, height_ff};
      hx = (hx != 16'd0) ? hx - 16'd1 : 16'd0;
      hy = (hy != 16'd0) ? hy - 16'd1 : 16'd0;
      ry = (p0 == 16'd0) ? 16'd1 : p0;
      rx = p1;
      if (rx == 16'd0 || rx > {8'd0, height_ff}) rx = {8'd0, height_ff};
      if (ry > {8'd0, rbot_ff}) ry = {8'd0, rbot_ff} + 16'd1;
   end

   // Byte decode
   always_comb begin
      d_cmd     = CMD_PUTCHAR;
      d_a       = 16'd0;
      d_b       = 16'd0;
      d_n       = 2'd0;
      d_colours = 1'b0;
      d_digit   = 1'b0;
      d_sep     = 1'b0;
      d_clear   = 1'b0;
      d_walk_m  = 1'b0;
      d_walk_d  = 1'b0;
      esc_in    = esc_ff;
      case (byte_ff)
         BYTE_NUL, BYTE_VT, BYTE_FF, BYTE_SO, BYTE_SI: begin
         end
         BYTE_CR, BYTE_TAB, BYTE_LF: begin
            d_n       = 2'd1;
            d_a       = {8'd0, byte_ff};
            d_colours = 1'b1;
         end
         BYTE_CAN, BYTE_SUB: begin
            esc_in = ESC_NORMAL;
         end
         BYTE_ESC: begin
            esc_in = ESC_ESC;
         end
         BYTE_CSI: begin
            esc_in = ESC_CSI;
         end
         BYTE_BS: begin
            d_n   = 2'd1;
            d_cmd = CMD_BACKSPACE;
            d_a   = (col_ff != 8'd0) ? {8'd0, col_ff - 8'd1} : 16'd0;
            d_b   = {8'd0, row_ff};
         end
         BYTE_BEL: begin
            d_n   = 2'd1;
            d_cmd = CMD_BELL;
         end
         default: begin
            case (esc_ff)
               ESC_NORMAL: begin
                  d_n       = 2'd1;
                  d_a       = {8'd0, byte_ff};
                  d_colours = 1'b1;
               end
               ESC_ESC: begin
                  esc_in = ESC_NORMAL;
                  case (byte_ff)
                     CH_LBRACK: esc_in = ESC_CSI;
                     CH_LPAREN: esc_in = ESC_G0;
                     CH_RPAREN: esc_in = ESC_G1;
                     CH_HASH:   esc_in = ESC_HASH;
                     CH_UC_P:   esc_in = ESC_DCS;
                     CH_UC_E: begin
                        // CR now, LF follows from the same result register
                        d_n       = 2'd2;
                        d_a       = {8'd0, BYTE_CR};
                        d_colours = 1'b1;
                     end
                     CH_LC_C: begin
                        d_n   = 2'd1;
                        d_cmd = CMD_RESET;
                     end
                     default: begin
                     end
                  endcase
               end
               ESC_CSI: begin
                  if (is_digit) begin
                     d_digit = 1'b1;
                  end else if (byte_ff == CH_SEMI) begin
                     d_sep = 1'b1;
                  end else if (byte_ff == CH_QUEST && p0 == 16'd0 && pidx_ff == '0) begin
                     esc_in = ESC_DEC;
                  end else begin
                     esc_in = ESC_NORMAL;
                     if (byte_ff == CH_LC_M) begin
                        d_walk_m = 1'b1;
                     end else begin
                        d_clear = 1'b1;
                     end
                     case (byte_ff)
                        CH_UC_A, CH_UC_B, CH_UC_C, CH_UC_D: begin
                           d_n   = 2'd1;
                           d_cmd = CMD_CURSOR;
                           d_a   = mx[15:0];
                           d_b   = my[15:0];
                        end
                        CH_UC_H: begin
                           d_n   = 2'd1;
                           d_cmd = CMD_CURSOR;
                           d_a   = hx;
                           d_b   = hy;
                        end
                        CH_UC_K: begin
                           if (p0 <= 16'd2) begin
                              d_n       = 2'd1;
                              d_cmd     = CMD_ERASE;
                              d_a       = p0;
                              d_b       = {8'd0, row_ff};
                              d_colours = 1'b1;
                           end
                        end
                        CH_UC_J: begin
                           if (p0 <= 16'd2) begin
                              d_n   = 2'd1;
                              d_cmd = CMD_CLEAR;
                           end
                        end
                        CH_UC_L: begin
                           d_n   = 2'd1;
                           d_cmd = CMD_INS_LINES;
                           d_a   = f;
                           d_b   = {8'd0, row_ff};
                        end
                        CH_UC_M: begin
                           d_n   = 2'd1;
                           d_cmd = CMD_DEL_LINES;
                           d_a   = f;
                           d_b   = {8'd0, row_ff};
                        end
                        CH_UC_P: begin
                           d_n   = 2'd1;
                           d_cmd = CMD_DEL_CHARS;
                           d_a   = f;
                        end
                        CH_AT: begin
                           d_n   = 2'd1;
                           d_cmd = CMD_INS_CHARS;
                           d_a   = f;
                        end
                        CH_LC_R: begin
                           d_n   = 2'd1;
                           d_cmd = CMD_REGION;
                           d_a   = ry - 16'd1;
                           d_b   = rx;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               ESC_DEC: begin
                  if (is_digit) begin
                     d_digit = 1'b1;
                  end else if (byte_ff == CH_SEMI) begin
                     d_sep = 1'b1;
                  end else begin
                     esc_in = ESC_NORMAL;
                     if (byte_ff == CH_LC_H || byte_ff == CH_LC_L) begin
                        d_walk_d = 1'b1;
                     end else begin
                        d_clear = 1'b1;
                     end
                  end
               end
               ESC_DCS: begin
               end
               default: begin
                  esc_in = ESC_NORMAL;
               end
            endcase
         end
      endcase
      if (!cmd.decode) esc_in = esc_ff;
   end

   // DEC mode walk step
   assign dec_on     = (byte_ff == CH_LC_H);
   assign walk_hit   = (rd_val == DEC_BELL && dec_on) || (rd_val == DEC_CURSOR);
   assign hit_cmd    = (rd_val == DEC_CURSOR) ? CMD_VISIBLE : CMD_BELL;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign step_stall = walk_hit && pend_valid_ff && !out_free;
   assign walk_done  = (walk_ff == pidx_ff);
   assign walk_end   = walk_done && (cmd.walk_m || (cmd.walk_d && !step_stall));

   assign stat.n_res      = d_n;
   assign stat.walk_m     = d_walk_m;
   assign stat.walk_d     = d_walk_d;
   assign stat.out_free   = out_free;
   assign stat.walk_done  = walk_done;
   assign stat.walk_stall = step_stall;
   assign stat.pend_after = pend_valid_ff || walk_hit;

   // SGR colour: 30..37 low bits plus two give 0..7; 40..47 low bits as is
   assign fg_code = rd_val[2:0] + 3'd2;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (cmd.walk_m) begin
         if (rd_val >= SGR_FG_LO && rd_val <= SGR_FG_HI) fg_in = fg_code;
         if (rd_val >= SGR_BG_LO && rd_val <= SGR_BG_HI) bg_in = rd_val[2:0];
         if (rd_val == SGR_RESET) begin
            fg_in = FG_DEFAULT;
            bg_in = BG_DEFAULT;
         end
         if (rd_val == SGR_FG_DEF) fg_in = FG_DEFAULT;
         if (rd_val == SGR_BG_DEF) bg_in = BG_DEFAULT;
      end
   end

   // Parameter store and index
   always_comb begin
      params_in = params_ff;
      pidx_in   = pidx_ff;
      if (cmd.decode) begin
         if (d_digit) params_in[pidx_ff] = digit_sum;
         if (d_sep && pidx_ff != IDX_MAX) pidx_in = pidx_ff + 1'b1;
      end
      if ((cmd.decode && d_clear) || walk_end) begin
         for (int i = 0; i < PARAM_SLOTS; i++) params_in[i] = 16'd0;
         pidx_in = '0;
      end
   end

   // Walk index and pending DEC result
   always_comb begin
      walk_in       = walk_ff;
      pend_valid_in = pend_valid_ff;
      pend_cmd_in   = pend_cmd_ff;
      pend_on_in    = pend_on_ff;
      if (cmd.decode) begin
         walk_in       = '0;
         pend_valid_in = 1'b0;
      end else if (cmd.walk_m) begin
         if (!walk_done) walk_in = walk_ff + 1'b1;
      end else if (cmd.walk_d && !step_stall) begin
         if (!walk_done) walk_in = walk_ff + 1'b1;
         if (walk_hit) begin
            pend_valid_in = 1'b1;
            pend_cmd_in   = hit_cmd;
            pend_on_in    = (rd_val == DEC_CURSOR) && dec_on;
         end
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_cmd_in   = out_cmd_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_fg_in    = out_fg_ff;
      out_bg_in    = out_bg_ff;
      out_last_in  = out_last_ff;
      if (cmd.send_res || cmd.send_lf) begin
         out_valid_in = 1'b1;
         out_cmd_in   = res_cmd_ff;
         out_a_in     = cmd.send_lf ? {8'd0, BYTE_LF} : res_a_ff;
         out_b_in     = res_b_ff;
         out_fg_in    = res_fg_ff;
         out_bg_in    = res_bg_ff;
         out_last_in  = cmd.last;
      end else if ((cmd.walk_d && !step_stall && walk_hit && pend_valid_ff) || cmd.flush) begin
         out_valid_in = 1'b1;
         out_cmd_in   = pend_cmd_ff;
         out_a_in     = {15'd0, pend_on_ff};
         out_b_in     = 16'd0;
         out_fg_in    = 3'd0;
         out_bg_in    = 3'd0;
         out_last_in  = cmd.flush;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 8'd80;
         height_ff     <= 8'd24;
         rtop_ff       <= 8'd0;
         rbot_ff       <= 8'd23;
         esc_ff        <= ESC_NORMAL;
         params_ff     <= '{default: 16'd0};
         pidx_ff       <= '0;
         fg_ff         <= FG_DEFAULT;
         bg_ff         <= BG_DEFAULT;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
               CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
               CSR_REGION_TOP:    rtop_ff   <= csr_wdata;
               CSR_REGION_BOTTOM: rbot_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         esc_ff        <= esc_in;
         params_ff     <= params_in;
         pidx_ff       <= pidx_in;
         fg_ff         <= fg_in;
         bg_ff         <= bg_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff <= byte_in;
         col_ff  <= cursor_col;
         row_ff  <= cursor_row;
      end
      if (cmd.decode) begin
         res_cmd_ff <= d_cmd;
         res_a_ff   <= d_a;
         res_b_ff   <= d_b;
         res_fg_ff  <= d_colours ? fg_ff : 3'd0;
         res_bg_ff  <= d_colours ? bg_ff : 3'd0;
      end
      walk_ff     <= walk_in;
      pend_cmd_ff <= pend_cmd_in;
      pend_on_ff  <= pend_on_in;
      out_cmd_ff  <= out_cmd_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_fg_ff   <= out_fg_in;
      out_bg_ff   <= out_bg_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_command = out_cmd_ff;
   assign rsp_arg_a   = out_a_ff;
   assign rsp_arg_b   = out_b_ff;
   assign rsp_fg      = out_fg_ff;
   assign rsp_bg      = out_bg_ff;
   assign rsp_last    = out_last_ff;

endmodule
